// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off during reset
`define PTD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check, also active during reset
`define PTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ptd_pkg.sv =====
package ptd_pkg;

  localparam int OP_W       = 2;
  localparam int PRESS_W    = 20;
  localparam int DEPTH_W    = 18;
  localparam int SAL_W      = 9;
  localparam int TMO_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam int DIVISOR_W  = 24;
  localparam int DIVIDEND_W = 40;
  localparam int QUOT_W     = 17;
  localparam int ITER_W     = 5;
  localparam int RHO_W      = 14;

  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_START  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SALINITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_REF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd2;

  localparam logic [PRESS_W-1:0] SCALE      = 20'd1000000;
  localparam logic [PRESS_W-1:0] GRAV_PAD   = 20'd981;
  localparam logic [RHO_W-1:0]   RHO_BASE   = 14'd9970;
  localparam logic [PRESS_W-1:0] REF_RESET  = 20'd87250;
  localparam logic [TMO_W-1:0]   TMO_RESET  = 8'd10;
  localparam logic [TMO_W-1:0]   TICK_MAX   = 8'd255;

  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ===== rtl/ptd_in_if.sv =====
interface ptd_in_if import ptd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [PRESS_W-1:0] pressure_pa;

  modport source (output valid, op, pressure_pa, input ready);
  modport sink (input valid, op, pressure_pa, output ready);
endinterface

// ===== rtl/ptd_out_if.sv =====
interface ptd_out_if import ptd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DEPTH_W-1:0] depth_mm;
  logic                      depth_valid;
  logic                      calib_busy;
  logic                      calib_done;
  logic                      calib_ok;
  logic [PRESS_W-1:0]        ref_pressure_pa;

  modport source (output valid, depth_mm, depth_valid, calib_busy, calib_done, calib_ok,
                  ref_pressure_pa, input ready);
  modport sink (input valid, depth_mm, depth_valid, calib_busy, calib_done, calib_ok,
                ref_pressure_pa, output ready);
endinterface

// ===== rtl/ptd_divider.sv =====
module ptd_divider import ptd_pkg::*; #(
  parameter int LOW_W = 25
) (
  input  logic                 clk,
  input  logic                 rst,
  input  div_cmd_t             cmd,
  input  logic [DIVISOR_W-1:0] rem_init,
  input  logic [LOW_W-1:0]     low_init,
  input  logic [DIVISOR_W-1:0] divisor,
  output div_sts_t             sts,
  output logic [LOW_W-1:0]     quotient
);

  logic [DIVISOR_W-1:0] rem;
  logic [LOW_W-1:0]     low;
  logic [DIVISOR_W-1:0] dvsr;
  logic [ITER_W-1:0]    cnt;
  logic                 busy;
  logic                 done;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   trial;
  logic                 qbit;

  // one restoring step per cycle
  assign shifted = {rem, low[LOW_W-1]};
  assign trial   = shifted - {1'b0, dvsr};
  assign qbit    = ~trial[DIVISOR_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.iters;
      end else if (busy) begin
        cnt <= cnt - ITER_W'(1);
        if (cnt == ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem  <= rem_init;
      low  <= low_init;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= qbit ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      low <= {low[LOW_W-2:0], qbit};
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign quotient = low;

endmodule

// ===== rtl/pressure_to_depth_with_zero_cal.sv =====
// Depth from pressure with zero-point calibration.
// Input channel meas carries op (sample, tick, start calibration) and pressure_pa;
// output channel rsp carries one result transaction per input transaction.
// Config port: cfg_wen, cfg_index, cfg_data; write only while the block is idle.
// A sample yields depth_mm = (ref - p) * 1e6 / ((9970 + salinity) * 981), truncated
// toward zero, computed against the reference held before the sample.
// A sample runs a bit-serial shift-add to form the scaled difference and the divisor,
// then the shared restoring divider, then the handoff to the output register. A tick
// that completes a full calibration runs the same divider to form the mean. Other
// transactions skip both steps. One transaction is in work at a time.
// A finished result sits in an output register; the next input is taken while it
// waits. When the receiver stalls, the block holds its next result until the
// register frees.
// Reset (synchronous, rst high): reference 87250 Pa, salinity 0, timeout 10 ticks,
// and a calibration starts with empty sum.
`include "assert_macros.svh"

module pressure_to_depth_with_zero_cal import ptd_pkg::*; #(
  parameter int SAMPLE_COUNT = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  ptd_in_if.sink                meas,
  ptd_out_if.source             rsp,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(SAMPLE_COUNT + 1);
  localparam int SUM_W = PRESS_W + CNT_W;
  localparam logic [CNT_W-1:0]  SC_FULL = CNT_W'(SAMPLE_COUNT);
  localparam logic [ITER_W-1:0] MUL_LAST = ITER_W'(PRESS_W - 1);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_OUT} state_t;

  state_t                    state;
  logic [ITER_W-1:0]         mcnt;
  logic [PRESS_W-1:0]        mag_sr;
  logic [DIVIDEND_W-1:0]     dividend;
  logic [DIVISOR_W-1:0]      divisor_acc;
  logic                      neg;
  logic                      mean_mode;
  logic                      div_go;
  logic                      r_valid;
  logic                      r_done;
  logic                      r_ok;

  logic                      o_valid;
  logic signed [DEPTH_W-1:0] o_depth;
  logic                      o_depth_valid;
  logic                      o_busy;
  logic                      o_done;
  logic                      o_ok;
  logic [PRESS_W-1:0]        o_ref;

  logic [SAL_W-1:0]          salinity;
  logic [TMO_W-1:0]          timeout;
  logic [PRESS_W-1:0]        reference;
  logic                      calibrating;
  logic [CNT_W-1:0]          held;
  logic [SUM_W-1:0]          sum;
  logic [TMO_W-1:0]          ticks;

  logic [PRESS_W:0]          diff;
  logic [PRESS_W-1:0]        mag;
  logic [TMO_W-1:0]          ticks_next;
  logic [RHO_W-1:0]          rho;
  logic [DEPTH_W-1:0]        depth_next;

  div_cmd_t                  div_cmd;
  div_sts_t                  div_sts;
  logic [DIVISOR_W-1:0]      div_rem_init;
  logic [SUM_W-1:0]          div_low_init;
  logic [DIVISOR_W-1:0]      div_divisor;
  logic [SUM_W-1:0]          quotient;

  assign diff       = {1'b0, reference} - {1'b0, meas.pressure_pa};
  assign mag        = diff[PRESS_W] ? (~diff[PRESS_W-1:0] + PRESS_W'(1)) : diff[PRESS_W-1:0];
  assign ticks_next = (ticks == TICK_MAX) ? TICK_MAX : ticks + TMO_W'(1);
  assign rho        = RHO_BASE + RHO_W'(salinity);
  assign depth_next = neg ? -{1'b0, quotient[QUOT_W-1:0]} : {1'b0, quotient[QUOT_W-1:0]};

  assign div_cmd.start = div_go;
  assign div_cmd.iters = mean_mode ? ITER_W'(SUM_W) : ITER_W'(QUOT_W);
  assign div_rem_init  = mean_mode ? '0 : DIVISOR_W'(dividend[DIVIDEND_W-1:QUOT_W]);
  assign div_low_init  = mean_mode ? sum
                                   : {dividend[QUOT_W-1:0], {(SUM_W - QUOT_W){1'b0}}};
  assign div_divisor   = mean_mode ? DIVISOR_W'(SAMPLE_COUNT) : divisor_acc;

  ptd_divider #(.LOW_W(SUM_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .cmd      (div_cmd),
    .rem_init (div_rem_init),
    .low_init (div_low_init),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quotient (quotient)
  );

  assign meas.ready          = (state == S_IDLE);
  assign rsp.valid           = o_valid;
  assign rsp.depth_mm        = o_depth;
  assign rsp.depth_valid     = o_depth_valid;
  assign rsp.calib_busy      = o_busy;
  assign rsp.calib_done      = o_done;
  assign rsp.calib_ok        = o_ok;
  assign rsp.ref_pressure_pa = o_ref;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      div_go      <= 1'b0;
      mean_mode   <= 1'b0;
      o_valid     <= 1'b0;
      salinity    <= '0;
      timeout     <= TMO_RESET;
      reference   <= REF_RESET;
      calibrating <= 1'b1;
      held        <= '0;
      sum         <= '0;
      ticks       <= '0;
    end else begin
      div_go <= 1'b0;
      if (rsp.ready) begin
        o_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (meas.valid) begin
            r_valid   <= 1'b0;
            r_done    <= 1'b0;
            r_ok      <= 1'b0;
            mean_mode <= 1'b0;
            state     <= S_OUT;
            case (meas.op)
              OP_SAMPLE: begin
                r_valid     <= 1'b1;
                neg         <= diff[PRESS_W];
                mag_sr      <= mag;
                dividend    <= '0;
                divisor_acc <= '0;
                mcnt        <= MUL_LAST;
                state       <= S_MUL;
                if (calibrating && held < SC_FULL) begin
                  sum  <= sum + SUM_W'(meas.pressure_pa);
                  held <= held + CNT_W'(1);
                end
              end
              OP_TICK: begin
                if (calibrating) begin
                  ticks <= ticks_next;
                  if (ticks_next > timeout || held >= SC_FULL) begin
                    r_done      <= 1'b1;
                    calibrating <= 1'b0;
                    if (held >= SC_FULL) begin
                      r_ok      <= 1'b1;
                      mean_mode <= 1'b1;
                      div_go    <= 1'b1;
                      state     <= S_DIV;
                    end
                  end
                end
              end
              OP_START: begin
                calibrating <= 1'b1;
                held        <= '0;
                sum         <= '0;
                ticks       <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_MUL: begin
          // msb-first shift-add of |diff| * 1e6 and (9970 + salinity) * 981
          dividend    <= {dividend[DIVIDEND_W-2:0], 1'b0}
                         + (mag_sr[PRESS_W-1] ? DIVIDEND_W'(SCALE) : '0);
          divisor_acc <= {divisor_acc[DIVISOR_W-2:0], 1'b0}
                         + (GRAV_PAD[mcnt] ? DIVISOR_W'(rho) : '0);
          mag_sr      <= {mag_sr[PRESS_W-2:0], 1'b0};
          mcnt        <= mcnt - ITER_W'(1);
          if (mcnt == '0) begin
            div_go <= 1'b1;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_sts.done) begin
            if (mean_mode) begin
              reference <= quotient[PRESS_W-1:0];
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!o_valid || rsp.ready) begin
            o_valid       <= 1'b1;
            o_depth       <= r_valid ? depth_next : '0;
            o_depth_valid <= r_valid;
            o_busy        <= calibrating;
            o_done        <= r_done;
            o_ok          <= r_ok;
            o_ref         <= reference;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (cfg_wen) begin
        case (cfg_index)
          REG_SALINITY: salinity  <= cfg_data[SAL_W-1:0];
          REG_INIT_REF: reference <= cfg_data[PRESS_W-1:0];
          REG_TIMEOUT:  timeout   <= cfg_data[TMO_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  `PTD_ASSERT(a_idle_div_quiet, clk, rst, meas.ready |-> !div_sts.busy, "divider busy while idle")
  `PTD_ASSERT(a_ok_needs_done, clk, rst, rsp.valid |-> (!rsp.calib_ok || rsp.calib_done), "calib_ok without calib_done")
  `PTD_ASSERT(a_sample_ends_nothing, clk, rst, (rsp.valid && rsp.depth_valid) |-> !rsp.calib_done, "sample reported end of calibration")
  `PTD_ASSERT(a_held_bound, clk, rst, held <= SC_FULL, "sample count beyond set size")

endmodule
